FILE: rtl/core/ltls_pkg.sv
// Shared types and constants for the last tagged line scanner.
`default_nettype none

package ltls_pkg;

  // Widest prefix the block compares, in bytes.
  localparam int unsigned MaxPrefix = 16;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned PrefLenW = 5;
  localparam int unsigned IdW      = 31;
  localparam int unsigned TotalW   = 32;

  localparam logic [IdW-1:0] IdMax = {IdW{1'b1}};

  // Byte codes seen in the text.
  localparam logic [7:0] CharLf    = 8'h0A;
  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] Char0     = 8'h30;
  localparam logic [7:0] Char9     = 8'h39;

  // Reset values of the configuration registers.
  localparam logic [CfgDataW-1:0] PrefixLowReset    = 64'd5786893821766946630;
  localparam logic [CfgDataW-1:0] PrefixHighReset   = 64'd32;
  localparam logic [PrefLenW-1:0] PrefixLengthReset = 5'd9;

  typedef enum logic [CfgIdxW-1:0] {
    CfgPrefixLow    = 2'd0,
    CfgPrefixHigh   = 2'd1,
    CfgPrefixLength = 2'd2
  } cfg_reg_e;

  // Where the scanner stands within the current line.
  typedef enum logic [3:0] {
    PhPrefix = 4'b0001,
    PhId     = 4'b0010,
    PhName   = 4'b0100,
    PhSkip   = 4'b1000
  } phase_e;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_t;

  typedef struct packed {
    logic [IdW-1:0]    op_id;
    logic [TotalW-1:0] announce_total;
    logic [7:0]        name_char;
    logic [6:0]        name_length;
    logic              name_cut;
    logic              id_saturated;
    logic              final_item;
  } out_t;

endpackage

`default_nettype wire

FILE: rtl/core/last_tagged_line_scanner.sv
// Top level of the last tagged line scanner: line parser, name store and answer readout.
//
// Input channel (in_valid_i / in_stall_o / in_data_i): one item per text byte, or an
// end-of-text marker. Text bytes, parsed on arrival one per unstalled cycle, give no
// result. A line counts when it starts with the configured prefix, then holds decimal
// digits, then optionally a space and a name, and ends in a newline.
// End of text snapshots the last good line and clears the parser. The answer then leaves
// on the output channel (out_valid_o / out_stall_i / out_data_o) as one item per kept
// name byte, or one item when the name is empty; final_item marks the last one.
// Throughput: one text byte per cycle while the input is not stalled. End of text is
// read out with one name RAM read per item while the input stalls. The first result
// passes through the RAM read register and then the output register.
// The output register lets the input move on while the last result waits to be taken.
// Output stall simply holds the output register and pauses the RAM reads.
// Configuration writes (cfg_we_i / cfg_index_i / cfg_data_i) are to be made by the user
// only while idle; the block itself does not enforce it.
// Reset: configuration returns to its defaults, parser and kept answer clear; the name RAM
// holds no reset, but only written entries are ever reported.
`default_nettype none

module last_tagged_line_scanner #(
  parameter int unsigned MAX_NAME = 32
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire ltls_pkg::in_t                  in_data_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output ltls_pkg::out_t                      out_data_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [ltls_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [ltls_pkg::CfgDataW-1:0]  cfg_data_i
);

  localparam int unsigned IdxW  = (MAX_NAME > 1) ? $clog2(MAX_NAME) : 1;
  localparam int unsigned LenW  = $clog2(MAX_NAME + 1);
  localparam int unsigned Depth = 2 * MAX_NAME;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned IdW   = ltls_pkg::IdW;
  localparam int unsigned TotW  = ltls_pkg::TotalW;

  // Configuration
  logic [ltls_pkg::CfgDataW-1:0] pre_low_q, pre_high_q;
  logic [ltls_pkg::PrefLenW-1:0] pre_len_q;

  // Line parser
  ltls_pkg::phase_e phase_q, phase_d;
  logic [4:0]      ppos_q, ppos_d;
  logic [IdW-1:0]  pid_q, pid_d;
  logic            povf_q, povf_d;
  logic            pdig_q, pdig_d;
  logic [LenW-1:0] stor_len_q, stor_len_d;
  logic [LenW-1:0] trim_len_q, trim_len_d;
  logic            pcut_q, pcut_d;

  // Last good line
  logic            bank_q, bank_d;
  logic [IdW-1:0]  kept_id_q, kept_id_d;
  logic [LenW-1:0] kept_len_q, kept_len_d;
  logic            kept_cut_q, kept_cut_d;
  logic            kept_ovf_q, kept_ovf_d;
  logic [TotW-1:0] count_q, count_d;

  // Readout snapshot and read pipeline
  logic [IdW-1:0]  snap_id_q;
  logic [TotW-1:0] snap_total_q;
  logic [LenW-1:0] snap_len_q;
  logic            snap_cut_q, snap_ovf_q, snap_bank_q;
  logic [LenW-1:0] rd_left_q;
  logic [IdxW-1:0] rd_idx_q;
  logic            rd_vld_q, rd_last_q;

  logic           out_vld_q;
  ltls_pkg::out_t out_data_q;

  logic             in_acc, eot_acc, byte_acc;
  logic [7:0]       tbyte;
  logic [4:0]       eff_len;
  logic [127:0]     pre_vec;
  logic [7:0]       pre_byte;
  logic             is_digit, is_space, trims;
  logic [IdW+3:0]   id_ext, id_calc;
  logic             id_big;
  logic             pre_open, do_id;
  logic             ram_we, ram_re;
  logic [AddrW-1:0] ram_waddr, ram_raddr;
  logic [7:0]       ram_rdata;
  logic             load_out, issue;

  assign in_stall_o = (rd_left_q != '0) || rd_vld_q;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign eot_acc    = in_acc && in_data_i.end_of_text;
  assign byte_acc   = in_acc && !in_data_i.end_of_text;
  assign tbyte      = in_data_i.text_byte;

  // ---------------- configuration ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_low_q  <= ltls_pkg::PrefixLowReset;
      pre_high_q <= ltls_pkg::PrefixHighReset;
      pre_len_q  <= ltls_pkg::PrefixLengthReset;
    end else if (cfg_we_i) begin
      case (ltls_pkg::cfg_reg_e'(cfg_index_i))
        ltls_pkg::CfgPrefixLow:    pre_low_q  <= cfg_data_i;
        ltls_pkg::CfgPrefixHigh:   pre_high_q <= cfg_data_i;
        ltls_pkg::CfgPrefixLength: pre_len_q  <= cfg_data_i[ltls_pkg::PrefLenW-1:0];
        default: ;
      endcase
    end
  end

  // Prefix length clamps to the compare width; zero means every line matches.
  assign eff_len  = (pre_len_q > 5'(ltls_pkg::MaxPrefix)) ? 5'(ltls_pkg::MaxPrefix)
                                                          : pre_len_q;
  assign pre_vec  = {pre_high_q, pre_low_q};
  assign pre_byte = pre_vec[ppos_q[3:0]*8 +: 8];

  // ---------------- byte classification and id arithmetic ----------------
  assign is_digit = tbyte inside {[ltls_pkg::Char0:ltls_pkg::Char9]};
  assign is_space = (tbyte == ltls_pkg::CharSpace);
  assign trims    = tbyte inside {ltls_pkg::CharSpace, ltls_pkg::CharCr};

  // id * 10 + digit; for ASCII digits the low nibble is the digit value
  assign id_ext  = {4'b0, pid_q};
  assign id_calc = (id_ext << 3) + (id_ext << 1) + (IdW+4)'(tbyte[3:0]);
  assign id_big  = id_calc > (IdW+4)'(ltls_pkg::IdMax);

  assign pre_open = ppos_q < eff_len;
  // Once the prefix is complete, the same byte is already the first id byte.
  assign do_id = (phase_q == ltls_pkg::PhId) || ((phase_q == ltls_pkg::PhPrefix) && !pre_open);

  // Name bytes go to the bank that is not committed.
  assign ram_waddr = (bank_q ? AddrW'(0) : AddrW'(MAX_NAME)) + AddrW'(stor_len_q[IdxW-1:0]);

  always_comb begin
    phase_d    = phase_q;
    ppos_d     = ppos_q;
    pid_d      = pid_q;
    povf_d     = povf_q;
    pdig_d     = pdig_q;
    stor_len_d = stor_len_q;
    trim_len_d = trim_len_q;
    pcut_d     = pcut_q;
    bank_d     = bank_q;
    kept_id_d  = kept_id_q;
    kept_len_d = kept_len_q;
    kept_cut_d = kept_cut_q;
    kept_ovf_d = kept_ovf_q;
    count_d    = count_q;
    ram_we     = 1'b0;

    if (eot_acc || (byte_acc && tbyte == ltls_pkg::CharLf)) begin
      // line end or end of text: a newline commits a good line first
      if (byte_acc && (phase_q inside {ltls_pkg::PhId, ltls_pkg::PhName}) && pdig_q) begin
        bank_d     = !bank_q;
        kept_id_d  = pid_q;
        kept_ovf_d = povf_q;
        kept_cut_d = pcut_q;
        kept_len_d = pcut_q ? LenW'(MAX_NAME) : trim_len_q;
        if (count_q != '1) begin
          count_d = count_q + TotW'(1);
        end
      end
      phase_d    = ltls_pkg::PhPrefix;
      ppos_d     = '0;
      pid_d      = '0;
      povf_d     = 1'b0;
      pdig_d     = 1'b0;
      stor_len_d = '0;
      trim_len_d = '0;
      pcut_d     = 1'b0;
      if (eot_acc) begin
        bank_d     = 1'b0;
        kept_id_d  = '0;
        kept_len_d = '0;
        kept_cut_d = 1'b0;
        kept_ovf_d = 1'b0;
        count_d    = '0;
      end
    end else if (byte_acc) begin
      if (phase_q == ltls_pkg::PhPrefix && pre_open) begin
        if (tbyte == pre_byte) begin
          ppos_d = ppos_q + 5'd1;
        end else begin
          phase_d = ltls_pkg::PhSkip;
        end
      end else if (do_id) begin
        phase_d = ltls_pkg::PhId;
        if (is_space) begin
          phase_d = ltls_pkg::PhName;
        end else if (is_digit) begin
          pdig_d = 1'b1;
          if (id_big) begin
            pid_d  = ltls_pkg::IdMax;
            povf_d = 1'b1;
          end else begin
            pid_d = id_calc[IdW-1:0];
          end
        end else begin
          phase_d = ltls_pkg::PhSkip;
        end
      end else if (phase_q == ltls_pkg::PhName) begin
        if (stor_len_q < LenW'(MAX_NAME)) begin
          ram_we     = 1'b1;
          stor_len_d = stor_len_q + LenW'(1);
          if (!trims) begin
            trim_len_d = stor_len_q + LenW'(1);
          end
        end else if (!trims) begin
          pcut_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= ltls_pkg::PhPrefix;
      ppos_q     <= '0;
      pid_q      <= '0;
      povf_q     <= 1'b0;
      pdig_q     <= 1'b0;
      stor_len_q <= '0;
      trim_len_q <= '0;
      pcut_q     <= 1'b0;
      bank_q     <= 1'b0;
      kept_id_q  <= '0;
      kept_len_q <= '0;
      kept_cut_q <= 1'b0;
      kept_ovf_q <= 1'b0;
      count_q    <= '0;
    end else begin
      phase_q    <= phase_d;
      ppos_q     <= ppos_d;
      pid_q      <= pid_d;
      povf_q     <= povf_d;
      pdig_q     <= pdig_d;
      stor_len_q <= stor_len_d;
      trim_len_q <= trim_len_d;
      pcut_q     <= pcut_d;
      bank_q     <= bank_d;
      kept_id_q  <= kept_id_d;
      kept_len_q <= kept_len_d;
      kept_cut_q <= kept_cut_d;
      kept_ovf_q <= kept_ovf_d;
      count_q    <= count_d;
    end
  end

  // ---------------- readout ----------------
  // Answer snapshot; stable for the whole readout since input stalls meanwhile.
  always_ff @(posedge clk_i) begin
    if (eot_acc) begin
      snap_id_q    <= kept_id_q;
      snap_total_q <= count_q;
      snap_len_q   <= kept_len_q;
      snap_cut_q   <= kept_cut_q;
      snap_ovf_q   <= kept_ovf_q;
      snap_bank_q  <= bank_q;
    end
  end

  assign load_out  = rd_vld_q && (!out_vld_q || !out_stall_i);
  assign issue     = (rd_left_q != '0) && (!rd_vld_q || load_out);
  assign ram_re    = issue;
  assign ram_raddr = (snap_bank_q ? AddrW'(MAX_NAME) : AddrW'(0)) + AddrW'(rd_idx_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_left_q <= '0;
      rd_idx_q  <= '0;
      rd_vld_q  <= 1'b0;
      rd_last_q <= 1'b0;
    end else if (eot_acc) begin
      // empty name still gives one item
      rd_left_q <= (kept_len_q == '0) ? LenW'(1) : kept_len_q;
      rd_idx_q  <= '0;
    end else if (issue) begin
      rd_left_q <= rd_left_q - LenW'(1);
      rd_idx_q  <= rd_idx_q + IdxW'(1);
      rd_vld_q  <= 1'b1;
      rd_last_q <= (rd_left_q == LenW'(1));
    end else if (load_out) begin
      rd_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (load_out) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_data_q.op_id          <= snap_id_q;
      out_data_q.announce_total <= snap_total_q;
      out_data_q.name_char      <= (snap_len_q == '0) ? 8'd0 : ram_rdata;
      out_data_q.name_length    <= 7'(snap_len_q);
      out_data_q.name_cut       <= snap_cut_q;
      out_data_q.id_saturated   <= snap_ovf_q;
      out_data_q.final_item     <= rd_last_q;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_data_q;

  ltls_ram #(
    .Width (8),
    .Depth (Depth)
  ) u_name_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (tbyte),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // ---------------- assertions ----------------
  a_eot_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eot_acc |=> in_stall_o)
    else $error("input not stalled after end of text");

  a_left_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_left_q <= LenW'(MAX_NAME))
    else $error("readout count beyond name store");

  a_trim_le_stored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (trim_len_q <= stor_len_q) && (stor_len_q <= LenW'(MAX_NAME)))
    else $error("name length bookkeeping broken");

  a_empty_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.name_length == 7'd0) |-> out_data_o.final_item)
    else $error("empty name answer not a single item");

endmodule

`default_nettype wire

FILE: rtl/core/ltls_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ltls_ram #(
  parameter  int unsigned Width = 8,
  parameter  int unsigned Depth = 64,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: tb/last_tagged_line_scanner_tb.sv
// Self-checking testbench for last_tagged_line_scanner: random text documents and a scoreboard.
`default_nettype none

module last_tagged_line_scanner_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxName = 32;

  // Scoreboard: follows the scanner one item at a time and keeps the answers that an
  // end of text should produce, oldest first.
  class line_answer_board;
    logic [ltls_pkg::CfgDataW-1:0] pfx_lo;
    logic [ltls_pkg::CfgDataW-1:0] pfx_hi;
    logic [ltls_pkg::PrefLenW-1:0] pfx_len;

    // line being parsed
    ltls_pkg::phase_e         phase;
    int unsigned              pos;
    logic [ltls_pkg::IdW-1:0] pend_id;
    bit                       pend_ovf;
    bit                       pend_digit;
    bit                       pend_cut;
    int unsigned              stored_len;
    int unsigned              trimmed_len;

    // two name banks: one holds the last good line, the other takes the current one
    logic [7:0]                  bank [2][MaxName];
    bit                          live_bank;
    logic [ltls_pkg::IdW-1:0]    kept_id;
    int unsigned                 kept_len;
    bit                          kept_cut;
    bit                          kept_ovf;
    logic [ltls_pkg::TotalW-1:0] good_lines;

    ltls_pkg::out_t answers[$];
    int unsigned    mismatches;

    function new();
      pfx_lo     = ltls_pkg::PrefixLowReset;
      pfx_hi     = ltls_pkg::PrefixHighReset;
      pfx_len    = ltls_pkg::PrefixLengthReset;
      mismatches = 0;
      clear();
    endfunction

    function void start_line();
      phase       = ltls_pkg::PhPrefix;
      pos         = 0;
      pend_id     = '0;
      pend_ovf    = 1'b0;
      pend_digit  = 1'b0;
      pend_cut    = 1'b0;
      stored_len  = 0;
      trimmed_len = 0;
    endfunction

    function void clear();
      start_line();
      foreach (bank[b, i]) bank[b][i] = 8'h00;
      live_bank  = 1'b0;
      kept_id    = '0;
      kept_len   = 0;
      kept_cut   = 1'b0;
      kept_ovf   = 1'b0;
      good_lines = '0;
    endfunction

    function void write_reg(ltls_pkg::cfg_reg_e idx, logic [ltls_pkg::CfgDataW-1:0] d);
      case (idx)
        ltls_pkg::CfgPrefixLow:    pfx_lo = d;
        ltls_pkg::CfgPrefixHigh:   pfx_hi = d;
        ltls_pkg::CfgPrefixLength: pfx_len = d[ltls_pkg::PrefLenW-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned prefix_span();
      return (pfx_len > ltls_pkg::MaxPrefix) ? ltls_pkg::MaxPrefix : int'(pfx_len);
    endfunction

    function logic [7:0] prefix_char(int unsigned at);
      int unsigned p;
      p = at & 15;
      if (p < 8) return pfx_lo[8*p +: 8];
      return pfx_hi[8*(p-8) +: 8];
    endfunction

    // newline: a line still in the id or name phase with at least one id digit becomes the kept answer
    function void end_line();
      if ((phase inside {ltls_pkg::PhId, ltls_pkg::PhName}) && pend_digit) begin
        live_bank ^= 1'b1;
        kept_id  = pend_id;
        kept_ovf = pend_ovf;
        kept_cut = pend_cut;
        kept_len = pend_cut ? MaxName : trimmed_len;
        if (good_lines != '1) good_lines++;
      end
      start_line();
    endfunction

    function void scan_byte(logic [7:0] b);
      longint unsigned acc;
      bit trims;
      if (b == ltls_pkg::CharLf) begin
        end_line();
        return;
      end
      if (phase == ltls_pkg::PhPrefix) begin
        if (pos < prefix_span()) begin
          if (b == prefix_char(pos)) pos++;
          else phase = ltls_pkg::PhSkip;
          return;
        end
        phase = ltls_pkg::PhId;
      end
      if (phase == ltls_pkg::PhId) begin
        if (b == ltls_pkg::CharSpace) begin
          phase = ltls_pkg::PhName;
        end else if (b inside {[ltls_pkg::Char0:ltls_pkg::Char9]}) begin
          acc = pend_id;
          acc = acc * 10 + (b - ltls_pkg::Char0);
          pend_digit = 1'b1;
          if (acc > ltls_pkg::IdMax) begin
            acc = ltls_pkg::IdMax;
            pend_ovf = 1'b1;
          end
          pend_id = acc[ltls_pkg::IdW-1:0];
        end else begin
          phase = ltls_pkg::PhSkip;
        end
        return;
      end
      if (phase == ltls_pkg::PhName) begin
        trims = b inside {ltls_pkg::CharCr, ltls_pkg::CharSpace};
        if (stored_len < MaxName) begin
          bank[live_bank ^ 1'b1][stored_len] = b;
          stored_len++;
          if (!trims) trimmed_len = stored_len;
        end else if (!trims) begin
          pend_cut = 1'b1;
        end
      end
    endfunction

    // end of text: one answer per kept name byte, or one if the name is empty
    function void emit_answer();
      ltls_pkg::out_t r;
      int unsigned n;
      n = (kept_len == 0) ? 1 : kept_len;
      for (int unsigned k = 0; k < n; k++) begin
        r.op_id          = kept_id;
        r.announce_total = good_lines;
        r.name_char      = (kept_len == 0) ? 8'h00 : bank[live_bank][k];
        r.name_length    = 7'(kept_len);
        r.name_cut       = kept_cut;
        r.id_saturated   = kept_ovf;
        r.final_item     = (k + 1 == n);
        answers.insert(answers.size(), r);
      end
      clear();
    endfunction

    function void note_input(ltls_pkg::in_t item);
      if (item.end_of_text) emit_answer();
      else scan_byte(item.text_byte);
    endfunction

    function string describe(ltls_pkg::out_t r);
      return $sformatf("id=%0d total=%0d char=%02h len=%0d cut=%0b sat=%0b last=%0b",
                       r.op_id, r.announce_total, r.name_char, r.name_length,
                       r.name_cut, r.id_saturated, r.final_item);
    endfunction

    function void complain(string msg);
      mismatches++;
      if (mismatches <= 10) $display("[%0t] mismatch: %s", $time, msg);
    endfunction

    function void check_output(ltls_pkg::out_t got);
      ltls_pkg::out_t want;
      if (answers.size() == 0) begin
        complain({"result with nothing pending: ", describe(got)});
        return;
      end
      want = answers.pop_front();
      if (got.op_id !== want.op_id || got.announce_total !== want.announce_total ||
          got.name_char !== want.name_char || got.name_length !== want.name_length ||
          got.name_cut !== want.name_cut || got.id_saturated !== want.id_saturated ||
          got.final_item !== want.final_item)
        complain({"expected ", describe(want), " got ", describe(got)});
    endfunction

    function void flush_leftovers();
      while (answers.size() != 0) complain({"never arrived: ", describe(answers.pop_front())});
    endfunction
  endclass

  logic clk;
  logic rst_n;

  logic                          in_valid  = 1'b0;
  logic                          in_stall;
  ltls_pkg::in_t                 in_data   = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  ltls_pkg::out_t                out_data;
  logic                          cfg_we    = 1'b0;
  logic [ltls_pkg::CfgIdxW-1:0]  cfg_index = ltls_pkg::CfgPrefixLow;
  logic [ltls_pkg::CfgDataW-1:0] cfg_data  = '0;

  line_answer_board board;
  logic [7:0]       line_bytes[$];  // text of the line being composed
  int unsigned      items_sent = 0;
  bit               calm = 1'b0;    // no idling or stalling while set

  last_tagged_line_scanner #(
    .MAX_NAME(MaxName)
  ) DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Receiver: random stalls, about one cycle in nine.
  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 11);
  end

  // Both handshakes are sampled at the rising edge. Results are checked before the input
  // of the same edge is noted; a result can never stem from an item taken at that edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) board.check_output(out_data);
      if (in_valid && !in_stall) board.note_input(in_data);
    end
  end

  // Appends one byte to the line being composed.
  function automatic void add_byte(logic [7:0] b);
    line_bytes.insert(line_bytes.size(), b);
  endfunction

  // Drives one item; called at a falling edge and returns at the falling edge after it
  // was taken. Valid stays high into the next item unless an idle gap is drawn.
  task automatic send_item(ltls_pkg::in_t item);
    if (!calm && $urandom_range(99) < 11) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic send_line_bytes();
    ltls_pkg::in_t item;
    foreach (line_bytes[i]) begin
      item.text_byte   = line_bytes[i];
      item.end_of_text = 1'b0;
      send_item(item);
    end
  endtask

  // text_byte is don't-care with end of text, so it carries noise
  task automatic send_eot();
    ltls_pkg::in_t item;
    item.text_byte   = 8'($urandom);
    item.end_of_text = 1'b1;
    send_item(item);
  endtask

  // Holds the sender until every answer is out, and then until the last text byte has
  // surely been parsed before anything else happens.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (board.answers.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  // All three registers, one per cycle; only called while the block is idle.
  task automatic program_prefix(input logic [ltls_pkg::CfgDataW-1:0] lo,
                                input logic [ltls_pkg::CfgDataW-1:0] hi,
                                input logic [ltls_pkg::PrefLenW-1:0] span);
    logic [ltls_pkg::CfgDataW-1:0] vals [3];
    ltls_pkg::cfg_reg_e            regs [3];
    vals = '{lo, hi, ltls_pkg::CfgDataW'(span)};
    regs = '{ltls_pkg::CfgPrefixLow, ltls_pkg::CfgPrefixHigh, ltls_pkg::CfgPrefixLength};
    for (int i = 0; i < 3; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      board.write_reg(regs[i], vals[i]);
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // Name byte: a fair share of CR and space so trimming happens mid-name and at the end.
  function automatic logic [7:0] name_byte();
    logic [7:0] c;
    if ($urandom_range(3) == 0) return $urandom_range(1) ? ltls_pkg::CharCr : ltls_pkg::CharSpace;
    do c = 8'($urandom); while (c == ltls_pkg::CharLf);
    return c;
  endfunction

  // Builds one line into line_bytes. Most lines are well formed (prefix, id, maybe a
  // name); the rest are short lines, noise, corrupted prefixes, empty or broken ids.
  // A torn line gets no newline, so the end of text that follows must drop it.
  function automatic void compose_line(bit torn);
    int unsigned kind;
    int unsigned span;
    int unsigned n;
    int unsigned spot;
    logic [7:0]  c;
    kind = $urandom_range(99);
    span = board.prefix_span();
    line_bytes.delete();
    for (int unsigned i = 0; i < span; i++) add_byte(board.prefix_char(i));
    if (kind < 6) begin
      // ends inside the prefix
      n = (span == 0) ? 0 : $urandom_range(span - 1);
      while (line_bytes.size() > n) line_bytes.delete(line_bytes.size() - 1);
    end else if (kind < 11) begin
      // raw noise, may hold newlines of its own
      repeat ($urandom_range(12)) add_byte(8'($urandom));
    end else begin
      if (kind < 18 && span > 0) begin
        spot = $urandom_range(span - 1);
        line_bytes[spot] = line_bytes[spot] ^ 8'($urandom_range(255, 1));
      end
      // 18..23: no id digits at all
      if (!(kind >= 18 && kind < 24)) begin
        // long ids mostly overflow the 31-bit range
        n = ($urandom_range(9) == 0) ? $urandom_range(12, 10) : $urandom_range(4, 1);
        repeat (n) add_byte(ltls_pkg::Char0 + 8'($urandom_range(9)));
        if (kind >= 24 && kind < 30) begin
          do c = 8'($urandom);
          while (c inside {[ltls_pkg::Char0:ltls_pkg::Char9], ltls_pkg::CharSpace,
                           ltls_pkg::CharLf});
          add_byte(c);
          repeat ($urandom_range(2)) add_byte(ltls_pkg::Char0 + 8'($urandom_range(9)));
        end
      end
      if ($urandom_range(99) < 65) begin
        add_byte(ltls_pkg::CharSpace);
        n = ($urandom_range(6) == 0) ? $urandom_range(40, 30) : $urandom_range(10);
        repeat (n) add_byte(name_byte());
        repeat ($urandom_range(2))
          add_byte($urandom_range(1) ? ltls_pkg::CharCr : ltls_pkg::CharSpace);
      end
    end
    if (!torn) add_byte(ltls_pkg::CharLf);
  endfunction

  // One document: a few lines, the last one sometimes torn, then end of text.
  task automatic send_document();
    int unsigned lines;
    lines = $urandom_range(4, 1);
    for (int unsigned l = 0; l < lines; l++) begin
      compose_line(l + 1 == lines && $urandom_range(99) < 15);
      send_line_bytes();
    end
    send_eot();
  endtask

  // Run limit: far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("last_tagged_line_scanner regression: fail");
    $finish;
  end

  initial begin
    int unsigned goal;
    board = new();
    rst_n = 1'b0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // Directed: no valid line at all, with the reset prefix.
    send_eot();
    wait_drained();

    // Directed, empty prefix so every line starts straight at the id: empty line,
    // non-digit id (byte 00), overflowing id with a name ending in CR and space,
    // then a torn line that must not count.
    program_prefix('0, '0, 5'd0);
    line_bytes = {ltls_pkg::CharLf, 8'h00, ltls_pkg::CharLf};
    repeat (11) add_byte(ltls_pkg::Char9);
    add_byte(ltls_pkg::CharSpace);
    add_byte(8'hFF);
    add_byte(8'h41);
    add_byte(ltls_pkg::CharCr);
    add_byte(ltls_pkg::CharSpace);
    add_byte(ltls_pkg::CharLf);
    send_line_bytes();
    send_eot();
    line_bytes = {ltls_pkg::Char0 + 8'd5};
    send_line_bytes();
    send_eot();
    wait_drained();

    // Random part: one prefix setting per phase, drained in between; the item goals
    // climb evenly to the total.
    for (int p = 0; p < 7; p++) begin
      case (p)
        0: program_prefix({$urandom, $urandom}, {$urandom, $urandom}, 5'd31);
        1: program_prefix({$urandom, $urandom}, {$urandom, $urandom}, 5'd0);
        2: program_prefix({$urandom, $urandom}, {$urandom, $urandom}, 5'd1);
        3: program_prefix('1, '1, 5'd16);
        4: program_prefix('0, '0, 5'd16);
        5: program_prefix(ltls_pkg::PrefixLowReset, ltls_pkg::PrefixHighReset,
                          ltls_pkg::PrefixLengthReset);
        default: program_prefix({$urandom, $urandom}, {$urandom, $urandom},
                                5'($urandom_range(15, 2)));
      endcase
      calm = (p == 3 || p == 4);  // long stretch at full rate on both sides
      goal = 410 * (p + 1) / 7;
      while (items_sent < goal) send_document();
      wait_drained();
      calm = 1'b0;
    end

    board.flush_leftovers();
    if (board.mismatches == 0) begin
      $display("last_tagged_line_scanner regression: pass");
    end else begin
      $display("last_tagged_line_scanner regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
rtl/core/ltls_pkg.sv
rtl/core/ltls_ram.sv
rtl/core/last_tagged_line_scanner.sv
tb/last_tagged_line_scanner_tb.sv
